// ===== rtl/sdsw_pkg.sv =====
`timescale 1ns / 1ps
// sdsw_pkg: shared types and constants for the speaker divisor square-wave block.
// No dependencies.
package sdsw_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MUTED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF     = 3'd4;

  // Register reset values
  localparam logic        MUTED_RST    = 1'b0;
  localparam logic [6:0]  AMP_RST      = 7'd63;
  localparam logic [7:0]  INTERVAL_RST = 8'd186;
  localparam logic [15:0] LIMIT_RST    = 16'd11160;
  localparam logic [23:0] COEF_RST     = 24'd310043;   // 44100 / 2386360, 0.24

  localparam logic [7:0]  MIDPOINT     = 8'd128;
  localparam logic [10:0] HALF_MAX     = 11'd2047;
  localparam logic [7:0]  TICK_MAX     = 8'hFF;
  localparam logic [15:0] SILENT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic        start_req;
    logic        stop;
    logic [15:0] divisor;
  } in_word_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       playing;
  } out_word_t;

  typedef struct packed {
    logic        muted;
    logic [6:0]  amplitude;
    logic [7:0]  tick_interval;
    logic [15:0] quiet_limit;
    logic [23:0] half_period_coef;
  } cfg_regs_t;

endpackage

// ===== rtl/sdsw_cfg_regs.sv =====
`timescale 1ns / 1ps
// sdsw_cfg_regs: configuration register file, written through the cfg channel.
// Depends on sdsw_pkg.
module sdsw_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [sdsw_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [sdsw_pkg::CFG_DATA_W-1:0]     wr_data,
  output sdsw_pkg::cfg_regs_t                 regs
);
  import sdsw_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (wr_index)
        CFG_MUTED:    regs_nxt.muted            = wr_data[0];
        CFG_AMP:      regs_nxt.amplitude        = wr_data[6:0];
        CFG_INTERVAL: regs_nxt.tick_interval    = wr_data[7:0];
        CFG_LIMIT:    regs_nxt.quiet_limit      = wr_data[15:0];
        CFG_COEF:     regs_nxt.half_period_coef = wr_data[23:0];
        default:      regs_nxt = regs_r;   // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.muted            <= MUTED_RST;
      regs_r.amplitude        <= AMP_RST;
      regs_r.tick_interval    <= INTERVAL_RST;
      regs_r.quiet_limit      <= LIMIT_RST;
      regs_r.half_period_coef <= COEF_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ===== rtl/sdsw_half_len.sv =====
`timescale 1ns / 1ps
// sdsw_half_len: half-period length in samples, clamp(divisor * coef >> 24, 1, 2047).
// Depends on sdsw_pkg.
module sdsw_half_len (
  input  logic [15:0] divisor,
  input  logic [23:0] coef,
  output logic [10:0] half_len
);
  import sdsw_pkg::*;

  logic [39:0] prod;
  logic [15:0] whole;

  assign prod  = 40'(divisor) * 40'(coef);
  assign whole = prod[39:24];

  always_comb begin
    if (whole == 16'd0) begin
      half_len = 11'd1;
    end else if (whole > 16'(HALF_MAX)) begin
      half_len = HALF_MAX;
    end else begin
      half_len = whole[10:0];
    end
  end

endmodule

// ===== rtl/sdsw_core.sv =====
`timescale 1ns / 1ps
// sdsw_core: playback state and the per-word step (tick fetch, silence, toggling).
// Depends on sdsw_pkg and sdsw_half_len.
module sdsw_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  sdsw_pkg::in_word_t   in_word,
  input  sdsw_pkg::cfg_regs_t  regs,
  output sdsw_pkg::out_word_t  result
);
  import sdsw_pkg::*;

  logic        active_r,     active_nxt;
  logic        level_high_r, level_high_nxt;
  logic [10:0] half_left_r,  half_left_nxt;
  logic [15:0] held_div_r,   held_div_nxt;
  logic [7:0]  tick_r,       tick_nxt;
  logic [15:0] silent_r,     silent_nxt;

  // Divisor held after a possible fetch; the same half length serves both
  // the fetch load and a boundary reload.
  logic [15:0] held_mid;
  logic [10:0] half_len;
  logic        run;
  logic        do_fetch;

  sdsw_half_len u_half (
    .divisor  (held_mid),
    .coef     (regs.half_period_coef),
    .half_len (half_len)
  );

  // First part: start/stop and fetch decision, feeding the multiplier operand
  always_comb begin
    logic       a;
    logic [15:0] hd;
    logic [15:0] st;
    logic [7:0]  tc;
    a  = active_r;
    hd = held_div_r;
    st = silent_r;
    tc = tick_r;
    if (in_word.start_req) begin
      hd = '0;
      tc = '0;
      st = '0;
      a  = 1'b1;
    end
    if (in_word.stop) begin
      a  = 1'b0;
      st = '0;
    end
    run      = a && !regs.muted && (st < regs.quiet_limit);
    do_fetch = run && (tc >= regs.tick_interval);
    held_mid = do_fetch ? in_word.divisor : hd;
  end

  always_comb begin
    logic        a;
    logic        lh;
    logic [10:0] hl;
    logic [15:0] st;
    logic [7:0]  tc;
    logic [7:0]  s;
    a  = active_r;
    lh = level_high_r;
    hl = half_left_r;
    st = silent_r;
    tc = tick_r;
    s  = MIDPOINT;
    if (in_word.start_req) begin
      lh = 1'b0;
      hl = '0;
      tc = '0;
      st = '0;
      a  = 1'b1;
    end
    if (in_word.stop) begin
      a  = 1'b0;
      st = '0;
    end
    if (!regs.muted && a) begin
      if (st >= regs.quiet_limit) begin
        a = 1'b0;                          // silence limit reached
      end else begin
        if (do_fetch) begin
          tc = '0;
          if (in_word.divisor == 16'd0) begin
            lh = 1'b0;
            hl = '0;
            if (st != SILENT_MAX) st = st + 16'd1;
          end else begin
            st = '0;
            hl = half_len;
            lh = !lh;
          end
        end
        if (tc != TICK_MAX) tc = tc + 8'd1;
        if (held_mid != 16'd0) begin
          if (hl == 11'd0) begin
            lh = !lh;
            hl = half_len;
          end
          hl = hl - 11'd1;
          s  = lh ? (MIDPOINT + {1'b0, regs.amplitude})
                  : (MIDPOINT - {1'b0, regs.amplitude});
        end
      end
    end
    active_nxt     = a;
    level_high_nxt = lh;
    half_left_nxt  = hl;
    held_div_nxt   = held_mid;
    tick_nxt       = tc;
    silent_nxt     = st;
    result.sample  = s;
    result.playing = a && !regs.muted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      level_high_r <= 1'b0;
      half_left_r  <= '0;
      held_div_r   <= '0;
      tick_r       <= '0;
      silent_r     <= '0;
    end else if (step) begin
      active_r     <= active_nxt;
      level_high_r <= level_high_nxt;
      half_left_r  <= half_left_nxt;
      held_div_r   <= held_div_nxt;
      tick_r       <= tick_nxt;
      silent_r     <= silent_nxt;
    end
  end

endmodule

// ===== rtl/speaker_divisor_square_wave.sv =====
`timescale 1ns / 1ps
// speaker_divisor_square_wave: top level, input and result registers around the core.
// Depends on sdsw_pkg, sdsw_cfg_regs and sdsw_core.
//
// Usage
//   in_*  : one word per audio sample slot (start_req, stop, timer divisor).
//   out_* : one word per input word, the 8-bit unsigned sample and playing flag.
//   cfg_* : register writes (0 muted, 1 amplitude, 2 tick_interval, 3 quiet_limit,
//           4 half_period_coef); cfg_ready is always high, indexes above four are
//           dropped. Write only while no word is in flight.
// Timing
//   A word in the input register is stepped, once the result slot is free, at the
//   edge that loads the result register and raises out_valid; it leaves when the
//   receiver takes it. Throughput is one word per cycle while out_ready is high: one
//   16x24 multiply, a clamp and counter updates sit between the input and the result register.
// Stall
//   When out_ready is low the result holds; one more word can wait in the
//   input register, after which in_ready drops. No word is lost or repeated.
// Reset
//   rst_n (synchronous, active low) empties both registers, stops playback and
//   loads the register defaults (amplitude 63, interval 186, limit 11160, coef 310043).
module speaker_divisor_square_wave (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sdsw_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sdsw_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sdsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdsw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sdsw_pkg::*;

  logic      in_vld_r;
  in_word_t  in_word_r;
  logic      out_vld_r;
  out_word_t out_word_r;
  cfg_regs_t regs;
  out_word_t result;
  logic      step;

  assign cfg_ready = 1'b1;

  sdsw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  // Step the core whenever a word waits and the result slot frees up
  assign step     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step;

  sdsw_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_word (in_word_r),
    .regs    (regs),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

endmodule

// ===== rtl/sdsw_checker.sv =====
`timescale 1ns / 1ps
// sdsw_checker: port-level assertions for speaker_divisor_square_wave, bound to the top.
// Depends on sdsw_pkg.
module sdsw_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input sdsw_pkg::out_word_t  out_data
);
  import sdsw_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Not playing means midpoint
  a_idle_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.playing |-> out_data.sample == MIDPOINT)
    else $error("non-midpoint sample while not playing");

  // Input back-pressure only comes from a stalled result
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled result");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind speaker_divisor_square_wave sdsw_checker u_sdsw_checker (.*);
